// ===== sv/rmsa_pkg.sv =====
package rmsa_pkg;

  typedef struct packed {
    logic [9:0]         cell_index;
    logic signed [31:0] sample_value;
    logic               end_of_sample;
  } rmsa_in_t;

  typedef struct packed {
    logic [9:0]         cell_echo;
    logic signed [31:0] running_mean;
    logic [31:0]        running_sd;
    logic [31:0]        count_used;
  } rmsa_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_LOAD,
    ST_DIV1,
    ST_MEAN,
    ST_MUL,
    ST_ACC,
    ST_DIV2,
    ST_SQRT,
    ST_DONE
  } rmsa_state_e;

endpackage

// ===== sv/running_mean_sd_accumulator.sv =====
// Channel  | Ports                          | Direction
// ---------+--------------------------------+----------
// command  | start_i, busy_o, in_i          | in
// result   | result_valid_o, result_o       | out
//
// An in-range command runs, from its transfer to the next possible transfer, through
// read and load, first divide (1 align + 32 quotient bits), mean, multiply, accumulate,
// second divide (64 quotient bits), 32 root steps, the result state and the idle state.
// An out-of-range cell goes from load straight to the result state.
// After reset the block clears the mean and m2 memories, one entry a cycle,
// with busy_o high. The receiver cannot stall the one-cycle strobe.
module running_mean_sd_accumulator
  import rmsa_pkg::*;
#(
  parameter int unsigned CELL_COUNT = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  rmsa_in_t  in_i,
  output logic      result_valid_o,
  output rmsa_out_t result_o
);

  localparam int unsigned AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  rmsa_state_e state_q, state_d;

  logic [31:0] mean_mem [CELL_COUNT];
  logic [63:0] m2_mem   [CELL_COUNT];
  logic [31:0] mean_rd_q;
  logic [63:0] m2_rd_q;

  logic [AW:0]   clr_q;
  rmsa_in_t      cmd_q;
  logic [31:0]   done_q;
  logic [31:0]   count_q;
  logic          inrange_q;

  // shared datapath registers
  logic [63:0] num_q;     // dividend being shifted out / root operand
  logic [63:0] rem_q;     // partial remainder
  logic [63:0] quo_q;     // quotient / root
  logic [6:0]  step_q;
  logic        neg_q;
  logic signed [32:0] delta_q;
  logic signed [31:0] newmean_q;
  logic [63:0] prod_q;
  logic [63:0] m2new_q;

  logic [AW-1:0] addr;
  assign addr = cmd_q.cell_index[AW-1:0];

  // magnitudes of delta and delta2, both fit in 32 bits
  logic [31:0] delta_mag, delta2_mag;
  always_comb begin
    delta_mag  = delta_q[32] ? 32'(-delta_q) : delta_q[31:0];
    delta2_mag = neg_q ? 32'(newmean_q - cmd_q.sample_value)
                       : 32'(cmd_q.sample_value - newmean_q);
  end

  // shared trial subtract
  logic [64:0] trial_rem, sub_val;
  logic [65:0] diff;
  always_comb begin
    trial_rem = {rem_q[63:0], num_q[63]};
    sub_val   = {33'd0, count_q};
    if (state_q == ST_SQRT) begin
      trial_rem = {rem_q[62:0], num_q[63:62]};
      sub_val   = {quo_q[62:0], 2'b01};
    end
    diff = {1'b0, trial_rem} - {1'b0, sub_val};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == (AW+1)'(CELL_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_READ;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = inrange_q ? ST_DIV1 : ST_DONE;
      ST_DIV1:  if (step_q == 7'd32) state_d = ST_MEAN;
      ST_MEAN:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_DIV2;
      ST_DIV2:  if (step_q == 7'd63) state_d = ST_SQRT;
      ST_SQRT:  if (step_q == 7'd31) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o         = (state_q != ST_IDLE);
    result_valid_o = (state_q == ST_DONE);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_DONE && cmd_q.end_of_sample) done_q <= count_q;
    end
  end

  // memories: clear sweep, read, write back
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      mean_mem[clr_q[AW-1:0]] <= '0;
      m2_mem[clr_q[AW-1:0]]   <= '0;
    end else if (state_q == ST_DIV2 && step_q == 7'd0) begin
      mean_mem[addr] <= newmean_q;
      m2_mem[addr]   <= m2new_q;
    end
    mean_rd_q <= mean_mem[addr];
    m2_rd_q   <= m2_mem[addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cmd_q     <= in_i;
        inrange_q <= (32'(in_i.cell_index) < CELL_COUNT);
        count_q   <= (done_q == 32'hFFFF_FFFF) ? done_q : done_q + 32'd1;
      end
      ST_LOAD: begin
        delta_q <= 33'(cmd_q.sample_value) - 33'(signed'(mean_rd_q));
        step_q  <= '0;
        rem_q   <= '0;
        quo_q   <= '0;
        neg_q   <= cmd_q.sample_value < signed'(mean_rd_q);
        num_q   <= (cmd_q.sample_value < signed'(mean_rd_q))
                   ? {31'd0, 33'(signed'(mean_rd_q)) - 33'(cmd_q.sample_value)}
                   : {31'd0, 33'(cmd_q.sample_value) - 33'(signed'(mean_rd_q))};
      end
      ST_DIV1, ST_DIV2: begin
        if (state_q == ST_DIV1 && step_q == 7'd0) begin
          // align the 32-bit magnitude to the top of the dividend
          num_q  <= {num_q[31:0], 32'd0};
          step_q <= step_q + 7'd1;
        end else if (state_q == ST_DIV2 && step_q == 7'd63) begin
          // hand the final quotient to the root loop
          num_q  <= !diff[65] ? {quo_q[62:0], 1'b1} : {quo_q[62:0], 1'b0};
          rem_q  <= '0;
          quo_q  <= '0;
          step_q <= '0;
        end else begin
          if (!diff[65]) begin
            rem_q <= diff[63:0];
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= trial_rem[63:0];
            quo_q <= {quo_q[62:0], 1'b0};
          end
          num_q  <= {num_q[62:0], 1'b0};
          step_q <= step_q + 7'd1;
        end
      end
      ST_MEAN: begin
        newmean_q <= neg_q ? signed'(mean_rd_q) - signed'(quo_q[31:0])
                           : signed'(mean_rd_q) + signed'(quo_q[31:0]);
      end
      ST_MUL: begin
        // |delta| < 2^32, |delta2| <= |delta|; 32x32 product
        prod_q <= 64'(delta_mag) * 64'(delta2_mag);
      end
      ST_ACC: begin
        m2new_q <= ({1'b0, m2_rd_q} + {1'b0, prod_q} > 65'h0_FFFF_FFFF_FFFF_FFFF)
                   ? 64'hFFFF_FFFF_FFFF_FFFF : m2_rd_q + prod_q;
        num_q   <= ({1'b0, m2_rd_q} + {1'b0, prod_q} > 65'h0_FFFF_FFFF_FFFF_FFFF)
                   ? 64'hFFFF_FFFF_FFFF_FFFF : m2_rd_q + prod_q;
        rem_q   <= '0;
        quo_q   <= '0;
        step_q  <= '0;
      end
      ST_SQRT: begin
        // two operand bits per step, one root bit
        if (!diff[65]) begin
          rem_q <= diff[63:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= trial_rem[63:0];
          quo_q <= {quo_q[62:0], 1'b0};
        end
        num_q  <= {num_q[61:0], 2'b00};
        step_q <= step_q + 7'd1;
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    result_o.cell_echo    = cmd_q.cell_index;
    result_o.running_mean = inrange_q ? newmean_q : '0;
    result_o.running_sd   = inrange_q ? quo_q[31:0] : '0;
    result_o.count_used   = count_q;
  end

endmodule

// ===== test/running_mean_sd_accumulator_tb.sv =====
`timescale 1ns / 1ps

module running_mean_sd_accumulator_tb;
  import rmsa_pkg::*;

  localparam int unsigned CELLS      = 1024;
  localparam int unsigned QUIET_MAX  = 5000;
  localparam int unsigned TAIL_WAIT  = 300;
  localparam int unsigned RAND_ITEMS = 2000;

  typedef struct {
    rmsa_in_t item;
    bit       drain;
  } pending_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  rmsa_in_t  in_i;
  logic      result_valid_o;
  rmsa_out_t result_o;

  running_mean_sd_accumulator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Shadow state of the accumulator
  logic signed [31:0] mean_mem [CELLS];
  logic [63:0]        m2_mem [CELLS];
  logic [31:0]        samples_done;

  pending_t  pending_q[$];
  rmsa_out_t stats_q[$];
  int        mismatches;
  int        quiet_cycles;
  bit        took_item;
  int        gap_cycles;
  bit        no_idle;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] floor_root(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'h1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  // Apply one Welford update to the shadow state and return the stats
  function automatic rmsa_out_t update_stats(rmsa_in_t t);
    rmsa_out_t   r;
    logic [31:0] cnt;
    longint      v, mu, delta, nm, d2, cl;
    logic [63:0] ma, mb, prod;
    logic [64:0] sum;
    cnt = (samples_done == 32'hFFFF_FFFF) ? samples_done : samples_done + 32'd1;
    r.cell_echo    = t.cell_index;
    r.running_mean = '0;
    r.running_sd   = '0;
    r.count_used   = cnt;
    if (t.cell_index < CELLS) begin
      v     = longint'(t.sample_value);
      mu    = longint'(mean_mem[t.cell_index]);
      cl    = longint'({32'b0, cnt});
      delta = v - mu;
      nm    = mu + delta / cl;
      d2    = v - nm;
      ma    = (delta < 0) ? 64'(-delta) : 64'(delta);
      mb    = (d2 < 0) ? 64'(-d2) : 64'(d2);
      prod  = ma * mb;
      sum   = {1'b0, m2_mem[t.cell_index]} + {1'b0, prod};
      m2_mem[t.cell_index]   = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      mean_mem[t.cell_index] = nm[31:0];
      r.running_mean         = nm[31:0];
      r.running_sd           = floor_root(m2_mem[t.cell_index] / {32'b0, cnt});
    end
    if (t.end_of_sample) samples_done = cnt;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    mismatches++;
  endtask

  task automatic queue_item(logic [9:0] c, logic [31:0] v, logic e);
    pending_t p;
    p.item.cell_index    = c;
    p.item.sample_value  = v;
    p.item.end_of_sample = e;
    p.drain              = 1'b0;
    pending_q = {pending_q, p};
  endtask

  // Sample transfers and check results at the rising edge
  always @(posedge clk_i) begin
    rmsa_out_t want;
    took_item <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (stats_q.size() == 0) begin
          report_mismatch("unexpected result, cell", 32'(result_o.cell_echo), 32'd0);
        end else begin
          want = stats_q.pop_front();
          if (result_o.cell_echo !== want.cell_echo)
            report_mismatch("cell_echo", 32'(result_o.cell_echo), 32'(want.cell_echo));
          if (result_o.running_mean !== want.running_mean)
            report_mismatch("running_mean", result_o.running_mean, want.running_mean);
          if (result_o.running_sd !== want.running_sd)
            report_mismatch("running_sd", result_o.running_sd, want.running_sd);
          if (result_o.count_used !== want.count_used)
            report_mismatch("count_used", result_o.count_used, want.count_used);
        end
      end
      if (start_i && !busy_o) begin
        stats_q = {stats_q, update_stats(in_i)};
      end
      if ((start_i && !busy_o) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog on cycles with no transfer and no result
  always @(posedge clk_i) begin
    if (quiet_cycles >= QUIET_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive commands at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i) begin
        if (took_item) begin
          start_i    <= 1'b0;
          gap_cycles <= no_idle ? 0 : $urandom_range(0, 3);
        end
      end else if (gap_cycles > 0) begin
        gap_cycles <= gap_cycles - 1;
      end else if (pending_q.size() > 0) begin
        if (pending_q[0].drain) begin
          // hold off until every outstanding result has arrived
          if (stats_q.size() == 0) void'(pending_q.pop_front());
        end else begin
          in_i    <= pending_q[0].item;
          start_i <= 1'b1;
          void'(pending_q.pop_front());
        end
      end
    end
  end

  initial begin
    pending_t p;
    logic [31:0] v;
    logic [9:0]  c;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    in_i         = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    took_item    = 1'b0;
    gap_cycles   = 0;
    no_idle      = 1'b0;
    samples_done = '0;
    for (int i = 0; i < CELLS; i++) begin
      mean_mem[i] = '0;
      m2_mem[i]   = '0;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme cells and values, count advance
    queue_item(10'd0,    32'h0000_0000, 1'b0);
    queue_item(10'd1023, 32'h7FFF_FFFF, 1'b0);
    queue_item(10'd1023, 32'h8000_0000, 1'b0);
    for (int i = 0; i < 6; i++)
      queue_item(10'd5, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b0);
    queue_item(10'd0,    32'hFFFF_FFFF, 1'b1);
    queue_item(10'd0,    32'h0001_0000, 1'b1);
    queue_item(10'd1023, 32'h8000_0000, 1'b1);
    queue_item(10'd5,    32'h7FFF_FFFF, 1'b0);
    queue_item(10'd2,    32'h0003_8000, 1'b1);
    queue_item(10'd2,    32'hFFFC_8000, 1'b0);
    queue_item(10'd512,  32'h5555_5555, 1'b1);
    queue_item(10'd341,  32'hAAAA_AAAA, 1'b0);
    p.item = '0;
    p.drain = 1'b1;
    pending_q = {pending_q, p};

    // Random: mostly a few cells with bounded values, some full-range noise
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 9) < 8) c = 10'($urandom_range(0, 15));
      else c = 10'($urandom);
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: v = 32'($signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000);
      endcase
      queue_item(c, v, $urandom_range(0, 7) == 0);
      if (i == RAND_ITEMS / 2) begin
        p.item = '0;
        p.drain = 1'b1;
        pending_q = {pending_q, p};
      end
    end

    // Alternate phases with and without idle gaps
    while (pending_q.size() > 0 || start_i) begin
      repeat (200) @(posedge clk_i);
      no_idle = ~no_idle;
    end
    while (stats_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
